@@ sv/fre_pkg.sv @@
// ----------------------------------------------------------------------------
// fre_pkg: shared definitions of the frame rate estimator
// Register indexes, field widths, reset values and the sequencer states.
// ----------------------------------------------------------------------------
package fre_pkg;

    localparam int TIME_W  = 32;
    localparam int RATE_W  = 32;
    localparam int GAIN_W  = 17;
    localparam int RATIO_W = 8;
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 2;

    // Remainder / product accumulator of the shared adder.
    localparam int ACC_W   = 50;
    // Dividend is ticks_per_second shifted up by the Q16.16 fraction.
    localparam int QUOT_W  = 48;
    localparam int CNT_W   = 6;

    localparam logic [INDEX_W-1:0] CFG_TICKS_PER_SECOND = 2'd0;
    localparam logic [INDEX_W-1:0] CFG_INIT_RATE        = 2'd1;
    localparam logic [INDEX_W-1:0] CFG_SMOOTHING_GAIN   = 2'd2;
    localparam logic [INDEX_W-1:0] CFG_OUTLIER_RATIO    = 2'd3;

    localparam logic [DATA_W-1:0]  RST_TICKS_PER_SECOND = 32'd1000000;
    localparam logic [RATE_W-1:0]  RST_INIT_RATE        = 32'd655360;
    localparam logic [GAIN_W-1:0]  RST_SMOOTHING_GAIN   = 17'd3277;
    localparam logic [RATIO_W-1:0] RST_OUTLIER_RATIO    = 8'd20;

    localparam logic [GAIN_W-1:0]  GAIN_ONE = 17'd65536;
    localparam logic [RATE_W-1:0]  RATE_MAX = 32'hFFFF_FFFF;

    typedef enum logic [8:0] {
        S_IDLE = 9'b0_0000_0001,
        S_DIV  = 9'b0_0000_0010,
        S_MUL1 = 9'b0_0000_0100,
        S_CHK1 = 9'b0_0000_1000,
        S_MUL2 = 9'b0_0001_0000,
        S_CHK2 = 9'b0_0010_0000,
        S_MULG = 9'b0_0100_0000,
        S_RND  = 9'b0_1000_0000,
        S_OUT  = 9'b1_0000_0000
    } t_state;

endpackage

@@ sv/frame_rate_estimator_top.sv @@
// ----------------------------------------------------------------------------
// frame_rate_estimator_top: moving average frame rate meter
// Turns frame timestamps into a smoothed Q16.16 frames-per-second estimate.
// ----------------------------------------------------------------------------
// Usage:
// One frame event enters on the input channel (i_in_valid / o_in_ready) with
// its timestamp. Each event gives exactly one result on the output channel
// (o_out_valid / i_out_ready): the estimate, the measured rate and two flags.
// Four registers are written over the configuration channel; its ready is
// always high, and writes are meant to happen only while the block is idle.
// Flow: a first frame or a zero interval goes straight to the output state.
// Otherwise a restoring divider runs, then the two outlier bound checks, each
// a multiply and a compare, and the weighted update with its rounding, all on
// one shared 50-bit adder; the checks end early for an outlier. A new item is
// taken once the result has entered the output register. The 48-step
// division sets most of the latency. The block takes one item at a time.
// A finished result waits in the output register; a stalled receiver holds
// back only the next result, never the item already being worked on.
// Reset restores the register defaults and forgets the previous timestamp, so
// the next event is treated as a first frame.
module frame_rate_estimator_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [fre_pkg::TIME_W-1:0]     i_frame_time,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [fre_pkg::RATE_W-1:0]     o_rate_estimate,
    output logic [fre_pkg::RATE_W-1:0]     o_measured_rate,
    output logic                           o_sample_accepted,
    output logic                           o_first_frame,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fre_pkg::INDEX_W-1:0]    i_cfg_index,
    input  logic [fre_pkg::DATA_W-1:0]     i_cfg_data
);

    localparam int ACC_W  = fre_pkg::ACC_W;
    localparam int QUOT_W = fre_pkg::QUOT_W;
    localparam int RATE_W = fre_pkg::RATE_W;

    // Configuration registers
    logic [fre_pkg::DATA_W-1:0]  r_tps;
    logic [RATE_W-1:0]           r_init;
    logic [fre_pkg::GAIN_W-1:0]  r_gain;
    logic [fre_pkg::RATIO_W-1:0] r_ratio;

    // Sequencer and datapath
    fre_pkg::t_state             r_state, n_state;
    logic [fre_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [ACC_W-1:0]            r_acc, n_acc;
    logic [QUOT_W-1:0]           r_quot, n_quot;
    logic [fre_pkg::TIME_W-1:0]  r_div, n_div;
    logic [fre_pkg::TIME_W-1:0]  r_prev, n_prev;
    logic                        r_have_prev, n_have_prev;
    logic [RATE_W-1:0]           r_est, n_est;
    logic [RATE_W-1:0]           r_meas, n_meas;
    logic                        r_accepted, n_accepted;
    logic                        r_first, n_first;

    // Output register
    logic                        r_out_valid, n_out_valid;
    logic [RATE_W-1:0]           r_out_est, n_out_est;
    logic [RATE_W-1:0]           r_out_meas, n_out_meas;
    logic                        r_out_acc, n_out_acc;
    logic                        r_out_first, n_out_first;

    // Shared adder
    logic [ACC_W-1:0]            alu_a, alu_b, alu_res;
    logic                        alu_sub;

    logic [fre_pkg::RATIO_W-1:0] ratio_eff;
    logic [fre_pkg::GAIN_W-1:0]  gain_eff;
    logic [RATE_W:0]             diff;
    logic [fre_pkg::TIME_W-1:0]  interval;
    logic [ACC_W-1:0]            div_shift;
    logic                        q_bit;
    logic [QUOT_W-1:0]           quot_next;
    logic                        in_fire, out_fire, out_free;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = r_out_valid && i_out_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign ratio_eff = (r_ratio == '0) ? fre_pkg::RATIO_W'(1) : r_ratio;
    assign gain_eff  = (r_gain > fre_pkg::GAIN_ONE) ? fre_pkg::GAIN_ONE : r_gain;
    assign diff      = {1'b0, r_meas} - {1'b0, r_est};
    assign interval  = i_frame_time - r_prev;

    assign div_shift = {r_acc[ACC_W-2:0], r_quot[QUOT_W-1]};
    assign alu_res   = alu_a + (alu_sub ? ~alu_b : alu_b) + ACC_W'(alu_sub);
    assign q_bit     = !alu_res[ACC_W-1];
    assign quot_next = {r_quot[QUOT_W-2:0], q_bit};

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            fre_pkg::S_DIV: begin
                // Trial subtraction of the divisor from the shifted remainder.
                alu_a   = div_shift;
                alu_b   = ACC_W'(r_div);
                alu_sub = 1'b1;
            end
            fre_pkg::S_MUL1: begin
                alu_a = {r_acc[ACC_W-2:0], 1'b0};
                alu_b = ratio_eff[r_cnt[2:0]] ? ACC_W'(r_meas) : '0;
            end
            fre_pkg::S_CHK1: begin
                // Negative means measured * ratio exceeds the estimate.
                alu_a   = ACC_W'(r_est);
                alu_b   = r_acc;
                alu_sub = 1'b1;
            end
            fre_pkg::S_MUL2: begin
                alu_a = {r_acc[ACC_W-2:0], 1'b0};
                alu_b = ratio_eff[r_cnt[2:0]] ? ACC_W'(r_est) : '0;
            end
            fre_pkg::S_CHK2: begin
                // Negative means measured lies below estimate * ratio.
                alu_a   = ACC_W'(r_meas);
                alu_b   = r_acc;
                alu_sub = 1'b1;
            end
            fre_pkg::S_MULG: begin
                // Gain * signed (measured - estimate), gain bits MSB first.
                alu_a = {r_acc[ACC_W-2:0], 1'b0};
                alu_b = gain_eff[r_cnt[4:0]] ?
                        {{(ACC_W-RATE_W-1){diff[RATE_W]}}, diff} : '0;
            end
            fre_pkg::S_RND: begin
                alu_a = r_acc;
                alu_b = ACC_W'({r_est, 16'h8000});
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_quot      = r_quot;
        n_div       = r_div;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_est       = r_est;
        n_meas      = r_meas;
        n_accepted  = r_accepted;
        n_first     = r_first;
        n_out_valid = out_fire ? 1'b0 : r_out_valid;
        n_out_est   = r_out_est;
        n_out_meas  = r_out_meas;
        n_out_acc   = r_out_acc;
        n_out_first = r_out_first;

        unique case (r_state)
            fre_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_prev     = i_frame_time;
                    n_div      = interval;
                    n_accepted = 1'b0;
                    n_first    = 1'b0;
                    if (!r_have_prev) begin
                        n_have_prev = 1'b1;
                        n_est       = r_init;
                        n_meas      = '0;
                        n_first     = 1'b1;
                        n_state     = fre_pkg::S_OUT;
                    end else if (interval == '0) begin
                        n_meas  = fre_pkg::RATE_MAX;
                        n_state = fre_pkg::S_OUT;
                    end else begin
                        n_quot  = {r_tps, 16'h0000};
                        n_acc   = '0;
                        n_cnt   = fre_pkg::CNT_W'(QUOT_W - 1);
                        n_state = fre_pkg::S_DIV;
                    end
                end
            end
            fre_pkg::S_DIV: begin
                n_acc  = q_bit ? alu_res : div_shift;
                n_quot = quot_next;
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_meas  = (quot_next[QUOT_W-1:RATE_W] != '0) ?
                              fre_pkg::RATE_MAX : quot_next[RATE_W-1:0];
                    n_acc   = '0;
                    n_cnt   = fre_pkg::CNT_W'(fre_pkg::RATIO_W - 1);
                    n_state = fre_pkg::S_MUL1;
                end
            end
            fre_pkg::S_MUL1: begin
                n_acc = alu_res;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = fre_pkg::S_CHK1;
                end
            end
            fre_pkg::S_CHK1: begin
                if (alu_res[ACC_W-1]) begin
                    n_acc   = '0;
                    n_cnt   = fre_pkg::CNT_W'(fre_pkg::RATIO_W - 1);
                    n_state = fre_pkg::S_MUL2;
                end else begin
                    n_state = fre_pkg::S_OUT;
                end
            end
            fre_pkg::S_MUL2: begin
                n_acc = alu_res;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = fre_pkg::S_CHK2;
                end
            end
            fre_pkg::S_CHK2: begin
                if (alu_res[ACC_W-1]) begin
                    n_acc   = '0;
                    n_cnt   = fre_pkg::CNT_W'(fre_pkg::GAIN_W - 1);
                    n_state = fre_pkg::S_MULG;
                end else begin
                    n_state = fre_pkg::S_OUT;
                end
            end
            fre_pkg::S_MULG: begin
                n_acc = alu_res;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = fre_pkg::S_RND;
                end
            end
            fre_pkg::S_RND: begin
                n_est      = alu_res[RATE_W+15:16];
                n_accepted = 1'b1;
                n_state    = fre_pkg::S_OUT;
            end
            fre_pkg::S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_est   = r_est;
                    n_out_meas  = r_meas;
                    n_out_acc   = r_accepted;
                    n_out_first = r_first;
                    n_state     = fre_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fre_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fre_pkg::S_IDLE;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
            r_tps       <= fre_pkg::RST_TICKS_PER_SECOND;
            r_init      <= fre_pkg::RST_INIT_RATE;
            r_gain      <= fre_pkg::RST_SMOOTHING_GAIN;
            r_ratio     <= fre_pkg::RST_OUTLIER_RATIO;
        end else begin
            r_state     <= n_state;
            r_have_prev <= n_have_prev;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    fre_pkg::CFG_TICKS_PER_SECOND: r_tps   <= i_cfg_data;
                    fre_pkg::CFG_INIT_RATE:        r_init  <= i_cfg_data;
                    fre_pkg::CFG_SMOOTHING_GAIN:   r_gain  <= i_cfg_data[fre_pkg::GAIN_W-1:0];
                    fre_pkg::CFG_OUTLIER_RATIO:    r_ratio <= i_cfg_data[fre_pkg::RATIO_W-1:0];
                    default:                       r_tps   <= r_tps;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_acc       <= n_acc;
        r_quot      <= n_quot;
        r_div       <= n_div;
        r_prev      <= n_prev;
        r_est       <= n_est;
        r_meas      <= n_meas;
        r_accepted  <= n_accepted;
        r_first     <= n_first;
        r_out_est   <= n_out_est;
        r_out_meas  <= n_out_meas;
        r_out_acc   <= n_out_acc;
        r_out_first <= n_out_first;
    end

    assign o_in_ready        = (r_state == fre_pkg::S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_rate_estimate   = r_out_est;
    assign o_measured_rate   = r_out_meas;
    assign o_sample_accepted = r_out_acc;
    assign o_first_frame     = r_out_first;

    // An accepted item keeps the block busy on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken on consecutive cycles");

    // A first frame only loads the estimate and never updates it.
    a_first_not_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_first_frame && o_sample_accepted))
        else $error("first frame reported as accepted sample");

    // An accepted sample lies above zero, since it must exceed estimate / ratio.
    a_accepted_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sample_accepted) |-> (o_measured_rate != '0))
        else $error("zero rate accepted");

    // Once a timestamp is held, only reset forgets it.
    a_prev_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_prev |=> r_have_prev)
        else $error("previous timestamp lost");

endmodule

@@ verif/frame_rate_estimator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rate_estimator_top_tb: self-checking bench of the frame rate meter
// Streams frame timestamps through the block and compares every result with
// a cycle-free predictor of the interval rate, the outlier band and the moving
// average update. A directed table covers the first frame, zero and extreme
// intervals and the register extremes; random phases follow under changing
// register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module frame_rate_estimator_top_tb;

    localparam int          TIME_W  = fre_pkg::TIME_W;
    localparam int          RATE_W  = fre_pkg::RATE_W;
    localparam int          GAIN_W  = fre_pkg::GAIN_W;
    localparam int          RATIO_W = fre_pkg::RATIO_W;
    localparam int          DATA_W  = fre_pkg::DATA_W;
    localparam int          INDEX_W = fre_pkg::INDEX_W;

    localparam int          HOLD_CYCLES = 400;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 56;
    localparam int          SETTLE      = 100;
    localparam longint      WATCHDOG_NS = 2_500_000;

    typedef enum logic [1:0] {ROW_CFG, ROW_FRAME_AT, ROW_FRAME_STEP} t_row_kind;
    // How much of a table row's result is typed in rather than predicted.
    typedef enum logic [1:0] {FIX_NONE, FIX_FLAGS, FIX_ALL} t_fix;

    typedef struct packed {
        logic [RATE_W-1:0] estimate;
        logic [RATE_W-1:0] measured;
        logic              accepted;
        logic              first_frame;
    } t_meter_result;

    typedef struct packed {
        t_row_kind          kind;
        logic [INDEX_W-1:0] index;
        logic [DATA_W-1:0]  value;
        t_fix               fix;
        t_meter_result      known;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [TIME_W-1:0]  i_frame_time;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [RATE_W-1:0]  o_rate_estimate;
    logic [RATE_W-1:0]  o_measured_rate;
    logic               o_sample_accepted;
    logic               o_first_frame;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [INDEX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]  i_cfg_data;

    // Predictor copy of the registers and the meter state.
    logic [DATA_W-1:0]  tps_reg     = fre_pkg::RST_TICKS_PER_SECOND;
    logic [RATE_W-1:0]  init_reg    = fre_pkg::RST_INIT_RATE;
    logic [GAIN_W-1:0]  gain_reg    = fre_pkg::RST_SMOOTHING_GAIN;
    logic [RATIO_W-1:0] ratio_reg   = fre_pkg::RST_OUTLIER_RATIO;
    logic [TIME_W-1:0]  prev_stamp  = '0;
    logic               stamp_seen  = 1'b0;
    logic [RATE_W-1:0]  rate_est    = '0;

    t_meter_result      pending_results[$];
    int                 fault_count = 0;
    int                 result_count = 0;

    t_fix               row_fix = FIX_NONE;
    t_meter_result      row_known = '0;
    t_stim_row          directed_rows[$];
    logic [TIME_W-1:0]  last_stamp = '0;

    bit                 hold_request = 1'b0;
    bit                 calm = 1'b0;
    bit                 quiet = 1'b0;

    frame_rate_estimator_top u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_frame_time      (i_frame_time),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_rate_estimate   (o_rate_estimate),
        .o_measured_rate   (o_measured_rate),
        .o_sample_accepted (o_sample_accepted),
        .o_first_frame     (o_first_frame),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("FAILURE");
        $finish;
    end

    // Advances the predicted meter by one frame event and returns its result.
    function automatic t_meter_result advance_meter(input logic [TIME_W-1:0] stamp);
        t_meter_result     res;
        logic [TIME_W-1:0] interval;
        logic [63:0]       quot;
        logic [63:0]       band;
        logic [63:0]       weight;
        logic [63:0]       sum;
        res = '0;
        if (!stamp_seen) begin
            stamp_seen      = 1'b1;
            rate_est        = init_reg;
            res.first_frame = 1'b1;
        end else begin
            interval = stamp - prev_stamp;
            band     = (ratio_reg == '0) ? 64'd1 : {56'b0, ratio_reg};
            weight   = (gain_reg > fre_pkg::GAIN_ONE) ?
                       {47'b0, fre_pkg::GAIN_ONE} : {47'b0, gain_reg};
            if (interval == '0) begin
                res.measured = fre_pkg::RATE_MAX;
            end else begin
                quot = {16'b0, tps_reg, 16'b0} / {32'b0, interval};
                res.measured = (quot > {32'b0, fre_pkg::RATE_MAX}) ?
                               fre_pkg::RATE_MAX : quot[31:0];
            end
            if (interval != '0 &&
                {32'b0, res.measured} * band > {32'b0, rate_est} &&
                {32'b0, res.measured} < {32'b0, rate_est} * band) begin
                sum = {32'b0, rate_est} * ({47'b0, fre_pkg::GAIN_ONE} - weight)
                    + {32'b0, res.measured} * weight + 64'd32768;
                rate_est     = sum[47:16];
                res.accepted = 1'b1;
            end
        end
        prev_stamp   = stamp;
        res.estimate = rate_est;
        return res;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_meter_result want;
        t_meter_result got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    fre_pkg::CFG_TICKS_PER_SECOND: tps_reg   = i_cfg_data;
                    fre_pkg::CFG_INIT_RATE:        init_reg  = i_cfg_data;
                    fre_pkg::CFG_SMOOTHING_GAIN:   gain_reg  = i_cfg_data[GAIN_W-1:0];
                    fre_pkg::CFG_OUTLIER_RATIO:    ratio_reg = i_cfg_data[RATIO_W-1:0];
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                got = '{o_rate_estimate, o_measured_rate, o_sample_accepted, o_first_frame};
                if (pending_results.size() == 0) begin
                    if (fault_count < 10)
                        $display("unexpected result %0d: est %h meas %h acc %b first %b",
                                 result_count, got.estimate, got.measured,
                                 got.accepted, got.first_frame);
                    fault_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        if (fault_count < 10) begin
                            $write("mismatch on result %0d: est exp %h got %h, ",
                                   result_count, want.estimate, got.estimate);
                            $display("meas exp %h got %h, acc exp %b got %b, first exp %b got %b",
                                     want.measured, got.measured, want.accepted,
                                     got.accepted, want.first_frame, got.first_frame);
                        end
                        fault_count++;
                    end
                end
                result_count++;
            end
            if (i_in_valid && o_in_ready) begin
                want = advance_meter(i_frame_time);
                case (row_fix)
                    FIX_FLAGS: begin
                        want.measured    = row_known.measured;
                        want.accepted    = row_known.accepted;
                        want.first_frame = row_known.first_frame;
                    end
                    FIX_ALL: want = row_known;
                    default: ;
                endcase
                pending_results.push_back(want);
            end
        end
    end

    // Receiver: random stall bursts, one long hold on request, none when quiet or calm.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic t_stim_row cfg_row(input logic [INDEX_W-1:0] index,
                                          input logic [DATA_W-1:0] value);
        return '{ROW_CFG, index, value, FIX_NONE, '0};
    endfunction

    function automatic t_stim_row frame_row(input t_row_kind kind,
                                            input logic [TIME_W-1:0] value,
                                            input t_fix fix,
                                            input logic [RATE_W-1:0] estimate,
                                            input logic [RATE_W-1:0] measured,
                                            input logic accepted,
                                            input logic first_frame);
        return '{kind, '0, value, fix, '{estimate, measured, accepted, first_frame}};
    endfunction

    task automatic idle_sender(input int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic offer_frame(input logic [TIME_W-1:0] stamp, input t_fix fix,
                               input t_meter_result known);
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_frame_time <= stamp;
        row_fix      <= fix;
        row_known    <= known;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        last_stamp = stamp;
    endtask

    // Stops offering frames until every predicted result has been taken.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_stim_row         row;
        logic [TIME_W-1:0] step;
        logic [63:0]       target;
        logic [63:0]       span;
        int unsigned       pick;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_frame_time = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;

        directed_rows.push_back(cfg_row(fre_pkg::CFG_INIT_RATE, 32'h003C_0000));
        // The first frame only loads the starting estimate.
        directed_rows.push_back(frame_row(ROW_FRAME_AT, 32'hFFFF_F000, FIX_ALL,
                                          32'h003C_0000, '0, 1'b0, 1'b1));
        // A 60 fps interval that wraps through zero.
        directed_rows.push_back(frame_row(ROW_FRAME_STEP, 32'd16667, FIX_NONE,
                                          '0, '0, 1'b0, 1'b0));
        directed_rows.push_back(frame_row(ROW_FRAME_STEP, 32'd0, FIX_FLAGS,
                                          '0, fre_pkg::RATE_MAX, 1'b0, 1'b0));
        directed_rows.push_back(frame_row(ROW_FRAME_STEP, 32'd1, FIX_FLAGS,
                                          '0, fre_pkg::RATE_MAX, 1'b0, 1'b0));
        directed_rows.push_back(frame_row(ROW_FRAME_STEP, 32'hFFFF_FFFF, FIX_NONE,
                                          '0, '0, 1'b0, 1'b0));
        directed_rows.push_back(cfg_row(fre_pkg::CFG_TICKS_PER_SECOND, 32'd0));
        directed_rows.push_back(frame_row(ROW_FRAME_STEP, 32'd1000, FIX_FLAGS,
                                          '0, '0, 1'b0, 1'b0));
        directed_rows.push_back(cfg_row(fre_pkg::CFG_TICKS_PER_SECOND, 32'hFFFF_FFFF));
        directed_rows.push_back(cfg_row(fre_pkg::CFG_SMOOTHING_GAIN,
                                        {15'b0, fre_pkg::GAIN_ONE}));
        directed_rows.push_back(cfg_row(fre_pkg::CFG_OUTLIER_RATIO, 32'd255));
        directed_rows.push_back(frame_row(ROW_FRAME_STEP, 32'd703687, FIX_NONE,
                                          '0, '0, 1'b0, 1'b0));
        // A saturated rate inside the band drives the estimate to full scale.
        directed_rows.push_back(frame_row(ROW_FRAME_STEP, 32'd1, FIX_ALL,
                                          fre_pkg::RATE_MAX, fre_pkg::RATE_MAX,
                                          1'b1, 1'b0));
        directed_rows.push_back(cfg_row(fre_pkg::CFG_SMOOTHING_GAIN, 32'h0001_FFFF));
        directed_rows.push_back(cfg_row(fre_pkg::CFG_OUTLIER_RATIO, 32'd0));
        directed_rows.push_back(frame_row(ROW_FRAME_STEP, 32'd1, FIX_FLAGS,
                                          '0, fre_pkg::RATE_MAX, 1'b0, 1'b0));
        directed_rows.push_back(cfg_row(fre_pkg::CFG_OUTLIER_RATIO, 32'd2));
        directed_rows.push_back(cfg_row(fre_pkg::CFG_SMOOTHING_GAIN, 32'd0));
        // Zero gain accepts the sample but leaves the estimate where it was.
        directed_rows.push_back(frame_row(ROW_FRAME_STEP, 32'd1, FIX_ALL,
                                          fre_pkg::RATE_MAX, fre_pkg::RATE_MAX,
                                          1'b1, 1'b0));
        directed_rows.push_back(cfg_row(fre_pkg::CFG_OUTLIER_RATIO, 32'd255));
        directed_rows.push_back(cfg_row(fre_pkg::CFG_SMOOTHING_GAIN,
                                        {15'b0, fre_pkg::GAIN_ONE}));
        directed_rows.push_back(frame_row(ROW_FRAME_STEP, 32'h0010_0000, FIX_ALL,
                                          32'h0FFF_FFFF, 32'h0FFF_FFFF, 1'b1, 1'b0));
        directed_rows.push_back(cfg_row(fre_pkg::CFG_TICKS_PER_SECOND, 32'd1));
        directed_rows.push_back(frame_row(ROW_FRAME_STEP, 32'd65536, FIX_FLAGS,
                                          '0, 32'd1, 1'b0, 1'b0));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            if (row.kind == ROW_CFG) begin
                drain_results();
                write_reg(row.index, row.value);
            end else begin
                if ($urandom_range(0, 3) == 0)
                    idle_sender($urandom_range(1, 7));
                offer_frame((row.kind == ROW_FRAME_AT) ? row.value : last_stamp + row.value,
                            row.fix, row.known);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            calm  = (phase == 0 || phase == 4);
            quiet = (phase == PHASES - 1);
            write_reg(fre_pkg::CFG_INIT_RATE, $urandom);
            case (phase)
                0: begin
                    write_reg(fre_pkg::CFG_TICKS_PER_SECOND,
                              fre_pkg::RST_TICKS_PER_SECOND);
                    write_reg(fre_pkg::CFG_SMOOTHING_GAIN,
                              {15'b0, fre_pkg::RST_SMOOTHING_GAIN});
                    write_reg(fre_pkg::CFG_OUTLIER_RATIO,
                              {24'b0, fre_pkg::RST_OUTLIER_RATIO});
                end
                2, 6: begin
                    write_reg(fre_pkg::CFG_TICKS_PER_SECOND, $urandom);
                    write_reg(fre_pkg::CFG_SMOOTHING_GAIN, $urandom);
                    write_reg(fre_pkg::CFG_OUTLIER_RATIO, $urandom);
                end
                3: begin
                    write_reg(fre_pkg::CFG_TICKS_PER_SECOND, 32'd1);
                    write_reg(fre_pkg::CFG_SMOOTHING_GAIN, {15'b0, fre_pkg::GAIN_ONE});
                    write_reg(fre_pkg::CFG_OUTLIER_RATIO, 32'd1);
                end
                4: begin
                    write_reg(fre_pkg::CFG_TICKS_PER_SECOND, 32'hFFFF_FFFF);
                    write_reg(fre_pkg::CFG_SMOOTHING_GAIN, 32'd1);
                    write_reg(fre_pkg::CFG_OUTLIER_RATIO, 32'd255);
                end
                default: begin
                    write_reg(fre_pkg::CFG_TICKS_PER_SECOND,
                              $urandom_range(1000, 32'hFFFF_FFFF));
                    write_reg(fre_pkg::CFG_SMOOTHING_GAIN, $urandom_range(0, 65536));
                    write_reg(fre_pkg::CFG_OUTLIER_RATIO, $urandom_range(2, 255));
                end
            endcase
            // The receiver holds off while frames keep coming, so the input stalls.
            if (phase == 0) begin
                @(posedge i_clk);
                hold_request = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 72) begin
                    // Plausible frame: a rate within half to one and a half of the
                    // current estimate, turned back into an interval.
                    target = ({32'b0, rate_est} * (32 + $urandom_range(0, 64))) >> 6;
                    if (target == 0) begin
                        step = $urandom;
                    end else begin
                        span = {16'b0, tps_reg, 16'b0} / target;
                        if (span == 0)
                            step = 32'd1;
                        else if (span > 64'hFFFF_FFFF)
                            step = 32'hFFFF_FFFF;
                        else
                            step = span[31:0];
                    end
                end else if (pick < 80) begin
                    step = '0;
                end else if (pick < 92) begin
                    step = $urandom;
                end else begin
                    step = $urandom_range(1, 15);
                end
                if (!calm && !quiet && $urandom_range(0, 3) == 0)
                    idle_sender($urandom_range(1, 7));
                offer_frame(last_stamp + step, FIX_NONE, '0);
                if (phase == 1 && n == 20)
                    drain_results();
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (fault_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
